// ----- src/pcmq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcmq_pkg
// Shared constants and types for the per-connection message queue.
// ----------------------------------------------------------------------------
package pcmq_pkg;
  localparam int Connections = 8;
  localparam int MsgBytes    = 64;
  localparam int Capacity    = 16;
  localparam int SlotW       = $clog2(Capacity);
  localparam int ByteW       = $clog2(MsgBytes);
  localparam int LenW        = $clog2(MsgBytes + 1);
  localparam int FillW       = $clog2(Capacity + 1);

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_OLDEST = 2'd2,
    OP_COUNT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_BADID = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_EMIT,
    S_RESP
  } state_t;

  // one arrival cell: slot number and owner, shifted as a unit
  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic [7:0]       owner;
  } entry_t;

  // control from the sequencer to the arrival chain
  typedef struct packed {
    logic             append;
    logic             remove;
    logic [SlotW-1:0] remove_pos;
    entry_t           app_entry;
  } chain_ctl_t;
endpackage
`default_nettype wire

// ----- src/per_connection_message_queue_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A push status, a count or a rejected pop is registered as a pending response and
// then loaded into the output register; a push item that is not last leaves the
// input ready in the next cycle. A pop walks the arrival chain one cell a cycle,
// closes the gap and primes the slot read in the shift state (a pop of the oldest
// skips the walk), then streams its bytes, each read before it is sent.
// Only one request is taken at a time. Reset: sync rst clears fill, counts, free map.
// ----------------------------------------------------------------------------
// per_connection_message_queue_unit
// Shared-store message queue with per-connection and global arrival order.
// ----------------------------------------------------------------------------
module per_connection_message_queue_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [4:0]  cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,  // op[1:0], conn_id[9:2], data_byte[17:10],
                                     // byte_valid[18], zeros
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,  // status[1:0], msg_conn[9:2], out_byte[17:10],
                                     // out_byte_valid[18], queue_count[23:19]
  output logic             m_tlast
);
  localparam int SW = pcmq_pkg::SlotW;
  localparam int FW = pcmq_pkg::FillW;
  localparam int LW = pcmq_pkg::LenW;
  localparam int BW = pcmq_pkg::ByteW;
  localparam int CW = $clog2(pcmq_pkg::Connections);

  logic [4:0] cap_limit;
  always_ff @(posedge clk) begin
    if (rst) cap_limit <= 5'd16;
    else if (cfg_we) cap_limit <= cfg_wdata;
  end
  logic [FW:0] eff_cap;
  always_comb begin
    if (cap_limit == 5'd0 || 32'(cap_limit) > pcmq_pkg::Capacity) begin
      eff_cap = (FW+1)'(pcmq_pkg::Capacity);
    end else begin
      eff_cap = (FW+1)'(cap_limit);
    end
  end

  pcmq_pkg::op_t op_in;
  logic [7:0] id_in, byte_in;
  logic bv_in;
  assign op_in   = pcmq_pkg::op_t'(s_tdata[1:0]);
  assign id_in   = s_tdata[9:2];
  assign byte_in = s_tdata[17:10];
  assign bv_in   = s_tdata[18];
  logic id_ok;
  assign id_ok = id_in >= 8'd1 && 32'(id_in) <= pcmq_pkg::Connections;

  // stores
  logic [7:0] mem [pcmq_pkg::Capacity * pcmq_pkg::MsgBytes];
  logic [LW-1:0] slot_len [pcmq_pkg::Capacity];
  logic [pcmq_pkg::Capacity-1:0] free_map;
  logic [FW-1:0] cnt [pcmq_pkg::Connections];

  pcmq_pkg::chain_ctl_t ctl;
  pcmq_pkg::entry_t ents [pcmq_pkg::Capacity];
  logic [FW-1:0] fill;
  pcmq_chain u_chain (.clk(clk), .rst(rst), .ctl(ctl), .entries(ents), .fill(fill));

  // push state
  logic push_act;
  pcmq_pkg::status_t push_st;
  logic [7:0] push_conn;
  logic [SW-1:0] push_slot;
  logic [LW-1:0] push_len;

  // first free slot (priority over 16 narrow bits)
  logic any_free;
  logic [SW-1:0] free_idx;
  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = pcmq_pkg::Capacity - 1; i >= 0; i--) begin
      if (free_map[i]) begin
        any_free = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  // sequencer
  pcmq_pkg::state_t state, state_next;
  logic [FW-1:0] pos;
  logic [7:0] want;
  logic [SW-1:0] cur_slot;
  logic [7:0] cur_owner;
  logic [LW-1:0] cur_len, emit_idx;
  logic resp_pend;
  logic [23:0] resp_data;
  logic rd_ok;

  logic out_busy;
  assign out_busy = m_tvalid && !m_tready;

  logic acc;
  assign s_tready = (state == pcmq_pkg::S_IDLE) && !resp_pend && !out_busy;
  assign acc = s_tvalid && s_tready;

  // a result leaves the emit stage once its byte has been read, or at once for an empty message
  logic emit_fire;
  assign emit_fire = (state == pcmq_pkg::S_EMIT) && !out_busy && (cur_len == '0 || rd_ok);

  pcmq_pkg::entry_t cur_ent;
  assign cur_ent = ents[pos[SW-1:0]];
  logic hit;
  assign hit = (pos < fill) && (cur_ent.owner == want);

  always_comb begin
    state_next = state;
    unique case (state)
      pcmq_pkg::S_IDLE: begin
        if (acc && (op_in == pcmq_pkg::OP_POP) && id_ok) state_next = pcmq_pkg::S_SEARCH;
        if (acc && (op_in == pcmq_pkg::OP_OLDEST) && fill != '0) state_next = pcmq_pkg::S_SHIFT;
      end
      pcmq_pkg::S_SEARCH: begin
        if (pos >= fill) state_next = pcmq_pkg::S_IDLE;
        else if (hit) state_next = pcmq_pkg::S_SHIFT;
      end
      pcmq_pkg::S_SHIFT: state_next = pcmq_pkg::S_EMIT;
      pcmq_pkg::S_EMIT: begin
        if (emit_fire && (emit_idx + 1'b1 >= cur_len)) state_next = pcmq_pkg::S_IDLE;
      end
      default: state_next = pcmq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    ctl.remove_pos = pos[SW-1:0];
    ctl.app_entry.slot = push_slot;
    ctl.app_entry.owner = push_conn;
    if (state == pcmq_pkg::S_SHIFT) ctl.remove = 1'b1;
    if (acc && op_in == pcmq_pkg::OP_PUSH && s_tlast) begin
      ctl.append = (push_act ? push_st : (id_ok ? ((32'(fill) >= 32'(eff_cap)
                    || !any_free) ? pcmq_pkg::ST_FULL : pcmq_pkg::ST_OK)
                    : pcmq_pkg::ST_BADID)) == pcmq_pkg::ST_OK;
      if (!push_act) begin
        ctl.app_entry.slot = free_idx;
        ctl.app_entry.owner = id_in;
      end
    end
  end

  function automatic logic [23:0] pack(pcmq_pkg::status_t st, logic [7:0] c,
                                       logic [7:0] b, logic v, logic [4:0] q);
    pack = {q, v, b, c, st};
  endfunction

  // push bookkeeping
  pcmq_pkg::status_t st_now;
  logic [SW-1:0] slot_now;
  logic [7:0] conn_now;
  always_comb begin
    st_now = push_st;
    slot_now = push_slot;
    conn_now = push_conn;
    if (!push_act) begin
      conn_now = id_in;
      slot_now = free_idx;
      if (!id_ok) st_now = pcmq_pkg::ST_BADID;
      else if (32'(fill) >= 32'(eff_cap) || !any_free) st_now = pcmq_pkg::ST_FULL;
      else st_now = pcmq_pkg::ST_OK;
    end
  end

  logic [LW-1:0] len_now;
  logic take_byte;
  assign len_now = push_act ? push_len : '0;
  assign take_byte = (st_now == pcmq_pkg::ST_OK) && bv_in
                     && 32'(len_now) < pcmq_pkg::MsgBytes;

  logic [CW-1:0] id_idx, conn_idx, owner_idx;
  assign id_idx    = CW'(id_in - 8'd1);
  assign conn_idx  = CW'(conn_now - 8'd1);
  assign owner_idx = CW'(cur_ent.owner - 8'd1);

  logic [7:0] rd_byte;

  always_ff @(posedge clk) begin
    if (acc && op_in == pcmq_pkg::OP_PUSH && take_byte) begin
      mem[{slot_now, len_now[BW-1:0]}] <= byte_in;
    end
    rd_byte <= mem[{cur_slot, emit_idx[BW-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcmq_pkg::S_IDLE;
      push_act <= 1'b0;
      push_len <= '0;
      free_map <= '1;
      for (int i = 0; i < pcmq_pkg::Connections; i++) cnt[i] <= '0;
      m_tvalid <= 1'b0;
      resp_pend <= 1'b0;
      rd_ok <= 1'b0;
    end else begin
      state <= state_next;
      if ((resp_pend && !out_busy) || emit_fire) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      rd_ok <= (state == pcmq_pkg::S_EMIT) && !out_busy && !rd_ok;
      if (resp_pend && !out_busy) begin
        m_tdata <= resp_data;
        m_tlast <= 1'b1;
        resp_pend <= 1'b0;
      end
      if (acc) begin
        unique case (op_in)
          pcmq_pkg::OP_PUSH: begin
            if (!push_act) begin
              push_st <= st_now;
              push_conn <= id_in;
              push_slot <= free_idx;
              if (st_now == pcmq_pkg::ST_OK) free_map[free_idx] <= 1'b0;
            end
            if (s_tlast) begin
              push_len <= '0;
            end else if (take_byte) begin
              push_len <= len_now + 1'b1;
            end else if (!push_act) begin
              push_len <= '0;
            end
            push_act <= !s_tlast;
            if (s_tlast) begin
              if (st_now == pcmq_pkg::ST_OK) begin
                slot_len[slot_now] <= take_byte ? len_now + 1'b1 : len_now;
                cnt[conn_idx] <= cnt[conn_idx] + 1'b1;
              end
              resp_pend <= 1'b1;
              resp_data <= pack(st_now, 8'd0, 8'd0, 1'b0, 5'd0);
            end
          end
          pcmq_pkg::OP_POP: begin
            pos <= '0;
            want <= id_in;
            if (!id_ok) begin
              resp_pend <= 1'b1;
              resp_data <= pack(pcmq_pkg::ST_BADID, 8'd0, 8'd0, 1'b0, 5'd0);
            end
          end
          pcmq_pkg::OP_OLDEST: begin
            pos <= '0;
            if (fill == '0) begin
              resp_pend <= 1'b1;
              resp_data <= pack(pcmq_pkg::ST_EMPTY, 8'd0, 8'd0, 1'b0, 5'd0);
            end
          end
          pcmq_pkg::OP_COUNT: begin
            resp_pend <= 1'b1;
            resp_data <= id_ok
              ? pack(pcmq_pkg::ST_OK, 8'd0, 8'd0, 1'b0, cnt[id_idx])
              : pack(pcmq_pkg::ST_BADID, 8'd0, 8'd0, 1'b0, 5'd0);
          end
          default: ;
        endcase
      end
      if (state == pcmq_pkg::S_SEARCH) begin
        if (pos >= fill) begin
          resp_pend <= 1'b1;
          resp_data <= pack(pcmq_pkg::ST_EMPTY, 8'd0, 8'd0, 1'b0, 5'd0);
        end else if (!hit) begin
          pos <= pos + 1'b1;
        end
      end
      if (state == pcmq_pkg::S_SHIFT) begin
        // detach the entry, free its slot, and prime the first byte read
        cur_slot <= cur_ent.slot;
        cur_owner <= cur_ent.owner;
        cur_len <= slot_len[cur_ent.slot];
        emit_idx <= '0;
        free_map[cur_ent.slot] <= 1'b1;
        if (cur_ent.owner >= 8'd1 && 32'(cur_ent.owner) <= pcmq_pkg::Connections
            && cnt[owner_idx] != '0) begin
          cnt[owner_idx] <= cnt[owner_idx] - 1'b1;
        end
      end
      if (emit_fire) begin
        if (cur_len == '0) begin
          m_tdata <= pack(pcmq_pkg::ST_OK, cur_owner, 8'd0, 1'b0, 5'd0);
          m_tlast <= 1'b1;
        end else begin
          m_tdata <= pack(pcmq_pkg::ST_OK, cur_owner, rd_byte, 1'b1, 5'd0);
          m_tlast <= (emit_idx + 1'b1 >= cur_len);
          emit_idx <= emit_idx + 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- src/pcmq_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcmq_cell
// One arrival-order cell: holds, loads from the tail or takes its neighbor.
// ----------------------------------------------------------------------------
module pcmq_cell (
  input  wire logic              clk,
  input  wire logic              load,
  input  wire logic              take_next,
  input  wire pcmq_pkg::entry_t  load_entry,
  input  wire pcmq_pkg::entry_t  next_entry,
  output pcmq_pkg::entry_t       entry
);
  always_ff @(posedge clk) begin
    if (take_next) begin
      entry <= next_entry;
    end else if (load) begin
      entry <= load_entry;
    end
  end
endmodule
`default_nettype wire

// ----- src/pcmq_chain.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcmq_chain
// Arrival list as a row of cells; removal shifts later cells into the gap.
// ----------------------------------------------------------------------------
module pcmq_chain (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire pcmq_pkg::chain_ctl_t           ctl,
  output pcmq_pkg::entry_t                    entries [pcmq_pkg::Capacity],
  output logic [pcmq_pkg::FillW-1:0]          fill
);
  logic [pcmq_pkg::FillW-1:0] tail;

  always_comb begin
    tail = fill;
    if (ctl.remove) begin
      tail = fill - 1'b1;
    end
  end

  for (genvar g = 0; g < pcmq_pkg::Capacity; g++) begin : g_cell
    logic ld;
    logic tk;
    pcmq_pkg::entry_t nx;
    assign ld = ctl.append && (tail == pcmq_pkg::FillW'(g));
    assign tk = ctl.remove && (pcmq_pkg::FillW'(g) >= {1'b0, ctl.remove_pos});
    if (g == pcmq_pkg::Capacity - 1) begin : g_end
      assign nx = entries[g];
    end else begin : g_mid
      assign nx = entries[g+1];
    end
    pcmq_cell u_cell (
      .clk        (clk),
      .load       (ld),
      .take_next  (tk),
      .load_entry (ctl.app_entry),
      .next_entry (nx),
      .entry      (entries[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= tail + pcmq_pkg::FillW'(ctl.append);
    end
  end
endmodule
`default_nettype wire

// ----- src/pcmq_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcmq_checker
// Port-level checks for the message queue unit.
// ----------------------------------------------------------------------------
module pcmq_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata,
  input wire logic        m_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result dropped while stalled");
  a_fail_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] == 2'd2 || m_tdata[1:0] == 2'd3) |-> m_tlast)
    else $error("failure status not final");
  a_byte_conn: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[18] |-> m_tdata[9:2] != 8'd0 && m_tdata[23:19] == 5'd0)
    else $error("byte result without owner");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("request taken while output stalled");
endmodule

bind per_connection_message_queue_unit pcmq_checker u_pcmq_checker (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
`default_nettype wire
